// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, register indices and helpers for the magnetometer sample
// conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

  // Default unity gain (Q2.14)
  localparam int unsigned UNITY_GAIN_DEF = 16384;
  // Calibration target field strength
  localparam int unsigned CAL_TARGET     = 700;
  // Scaled product shift
  localparam int unsigned GAIN_SHIFT     = 14;
  // Stuck counter: restart once the old count exceeds this
  localparam logic [2:0]  STUCK_LIMIT    = 3'd4;
  localparam logic [2:0]  STUCK_SAT      = 3'd7;

  // Configuration register indices
  localparam logic [2:0] REG_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd2;
  localparam logic [2:0] REG_MAX_MAG    = 3'd3;
  localparam logic [2:0] REG_MIN_CAL    = 3'd4;
  localparam logic [2:0] REG_AXIS_MAP   = 3'd5;
  localparam logic [2:0] REG_AXIS_NEG   = 3'd6;

  // Register reset values
  localparam logic [14:0] MAX_MAG_RST   = 15'd1000;
  localparam logic [14:0] MIN_CAL_RST   = 15'd300;
  localparam logic [5:0]  AXIS_MAP_RST  = 6'd36;

  // Item kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_CAL    = 1'b1;

  typedef logic [2:0][15:0] vec3_t;

  typedef struct packed {
    vec3_t       offset;
    logic [14:0] max_mag;
    logic [14:0] min_cal;
    logic [5:0]  axis_map;
    logic [2:0]  axis_neg;
  } cfg_t;

  typedef struct packed {
    vec3_t body;
    vec3_t filt;
    logic  data_valid;
    logic  restart;
  } res_t;

  // Signed divide by eight, truncating toward zero
  function automatic logic [15:0] div8_trunc(input logic [15:0] v);
    logic [15:0] q;
    q = {{3{v[15]}}, v[15:3]};
    if (v[15] && (v[2:0] != 3'd0)) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/msc_div.sv =====
// ----------------------------------------------------------------------------
// msc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_div #(
  parameter int unsigned DividendW = 24,
  parameter int unsigned DivisorW  = 15
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DividendW-1:0] quo_q;

  logic [DivisorW:0] trial;
  logic [DivisorW:0] diff;
  logic              fits;

  // Trial subtraction of the shifted remainder
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_q <= {quo_q[DividendW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/msc_core.sv =====
// ----------------------------------------------------------------------------
// msc_core
// Sequencer, shared multiplier and per-axis state of the conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_core #(
  parameter int unsigned UnityGain = msc_pkg::UNITY_GAIN_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire msc_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          kind_i,
  input  wire msc_pkg::vec3_t raw_i,
  output logic               res_valid_o,
  input  wire logic          res_take_i,
  output msc_pkg::res_t      res_o
);

  localparam int unsigned DivW = $clog2(msc_pkg::CAL_TARGET * UnityGain + 1);
  localparam logic [DivW-1:0] CalDividend = DivW'(msc_pkg::CAL_TARGET * UnityGain);
  localparam logic [15:0]     UnityW      = 16'(UnityGain);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_CAL   = 3'd3;
  localparam logic [2:0] S_CWAIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state_q;
  logic [1:0]      axis_q;
  logic            kind_q;
  msc_pkg::vec3_t  raw_q, prev_q, filt_q, gain_q, body_q;
  logic [2:0]      same_cnt_q;
  logic signed [32:0] prod_q;
  logic            valid_q, restart_q;

  // Axis selection for the multiplier
  logic [1:0]  sel;
  logic [15:0] mul_raw, mul_gain;
  logic signed [32:0] prod;

  always_comb begin
    sel = cfg_i.axis_map[2*axis_q +: 2];
    if (sel == 2'd3) begin
      sel = 2'd2;
    end
  end

  assign mul_raw  = raw_q[sel];
  assign mul_gain = gain_q[sel];
  assign prod     = $signed({mul_raw[15], mul_raw}) * $signed({1'b0, mul_gain});

  // Body value from the registered product
  logic [15:0] scaled, body_val;
  always_comb begin
    scaled = prod_q[msc_pkg::GAIN_SHIFT+15:msc_pkg::GAIN_SHIFT];
    if (cfg_i.axis_neg[axis_q]) begin
      scaled = 16'd0 - scaled;
    end
    body_val = scaled - {cfg_i.offset[axis_q][15], cfg_i.offset[axis_q][15:1]};
  end

  // Magnitude and filter for the current axis
  logic [15:0] cur_raw, mag, filt_new;
  assign cur_raw  = raw_q[axis_q];
  assign mag      = cur_raw[15] ? (16'd0 - cur_raw) : cur_raw;
  assign filt_new = filt_q[axis_q] - msc_pkg::div8_trunc(filt_q[axis_q])
                    + msc_pkg::div8_trunc(cur_raw);

  // Stuck-sensor check
  logic same;
  assign same = (raw_q == prev_q);

  // Calibration acceptance window
  logic cal_ok;
  assign cal_ok = ($signed(cur_raw) > $signed({1'b0, cfg_i.min_cal}))
               && ($signed(cur_raw) < $signed({1'b0, cfg_i.max_mag}));

  // Shared divider
  logic            div_start, div_busy, div_done;
  logic [DivW-1:0] div_quo;
  logic [15:0]     div_gain;

  assign div_start = (state_q == S_CAL) && cal_ok;
  assign div_gain  = (div_quo[DivW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];

  msc_div #(
    .DividendW (DivW),
    .DivisorW  (15)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (CalDividend),
    .divisor_i  (cur_raw[14:0]),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer and per-axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= 2'd0;
      same_cnt_q <= 3'd0;
      prev_q     <= '0;
      filt_q     <= '0;
      gain_q     <= {3{UnityW}};
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            axis_q  <= 2'd0;
            state_q <= (kind_i == msc_pkg::KIND_CAL) ? S_CAL : S_MUL;
          end
        end
        S_MUL: begin
          if (axis_q == 2'd0) begin
            if (same) begin
              if (same_cnt_q != msc_pkg::STUCK_SAT) begin
                same_cnt_q <= same_cnt_q + 3'd1;
              end
            end else begin
              same_cnt_q <= 3'd0;
            end
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          filt_q[axis_q] <= filt_new;
          prev_q[axis_q] <= cur_raw;
          if (axis_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_CAL: begin
          if (cal_ok) begin
            state_q <= S_CWAIT;
          end else begin
            gain_q[axis_q] <= UnityW;
            if (axis_q == 2'd2) begin
              state_q <= S_DONE;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        S_CWAIT: begin
          if (div_done) begin
            gain_q[axis_q] <= div_gain;
            if (axis_q == 2'd2) begin
              state_q <= S_DONE;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_CAL;
            end
          end
        end
        S_DONE: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item payload and per-item flags
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_q    <= kind_i;
          raw_q     <= raw_i;
          valid_q   <= 1'b1;
          restart_q <= 1'b0;
        end
      end
      S_MUL: begin
        prod_q <= prod;
        if (axis_q == 2'd0 && same && same_cnt_q > msc_pkg::STUCK_LIMIT) begin
          restart_q <= 1'b1;
        end
      end
      S_ACC: begin
        body_q[axis_q] <= body_val;
        if (mag >= {1'b0, cfg_i.max_mag}) begin
          valid_q <= 1'b0;
        end
      end
      S_CAL: begin
        if (!cal_ok) begin
          restart_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result
  logic normal;
  assign normal      = (kind_q == msc_pkg::KIND_NORMAL);
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.body       = normal ? body_q : '0;
    res_o.filt       = filt_q;
    res_o.data_valid = normal && valid_q;
    res_o.restart    = restart_q || (normal && !valid_q);
  end

  // The divider only runs inside a calibration item
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  // A quotient only arrives while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_CWAIT))
    else $error("divider result not awaited");

  // Calibration items leave the stuck counter and filter untouched
  a_cal_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && kind_q == msc_pkg::KIND_CAL)
      |=> ($stable(same_cnt_q) && $stable(filt_q)))
    else $error("calibration item changed filter state");

endmodule

`default_nettype wire

// ===== rtl/magnetometer_sample_conditioner_top.sv =====
// Sequence: a normal item is accepted, then each axis in turn gets a multiply
// and an accumulate step on the one shared multiplier, then the output register.
// A calibration item runs the radix-2 divider once per accepted axis, in turn;
// a rejected axis gets unity gain and skips the divider.
// Flow: one item at a time; a new item is taken only while the sequencer is idle.
// Reset: registers to defaults, gains to unity, filter and history cleared.
// ----------------------------------------------------------------------------
// magnetometer_sample_conditioner_top
// Configuration registers, output register and the conditioning core.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_sample_conditioner_top #(
  parameter int unsigned UnityGain = msc_pkg::UNITY_GAIN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  x_high_i,
  input  wire logic [7:0]  x_low_i,
  input  wire logic [7:0]  y_high_i,
  input  wire logic [7:0]  y_low_i,
  input  wire logic [7:0]  z_high_i,
  input  wire logic [7:0]  z_low_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [15:0] body_x_o,
  output logic signed [15:0] body_y_o,
  output logic signed [15:0] body_z_o,
  output logic signed [15:0] filtered_x_o,
  output logic signed [15:0] filtered_y_o,
  output logic signed [15:0] filtered_z_o,
  output logic             data_valid_o,
  output logic             restart_request_o
);

  msc_pkg::cfg_t  cfg_q;
  msc_pkg::vec3_t raw;
  msc_pkg::res_t  core_res, res_q;
  logic           core_valid, res_take, out_valid_q;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset   <= '0;
      cfg_q.max_mag  <= msc_pkg::MAX_MAG_RST;
      cfg_q.min_cal  <= msc_pkg::MIN_CAL_RST;
      cfg_q.axis_map <= msc_pkg::AXIS_MAP_RST;
      cfg_q.axis_neg <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        msc_pkg::REG_OFFSET_X: cfg_q.offset[0] <= cfg_data_i;
        msc_pkg::REG_OFFSET_Y: cfg_q.offset[1] <= cfg_data_i;
        msc_pkg::REG_OFFSET_Z: cfg_q.offset[2] <= cfg_data_i;
        msc_pkg::REG_MAX_MAG:  cfg_q.max_mag   <= cfg_data_i[14:0];
        msc_pkg::REG_MIN_CAL:  cfg_q.min_cal   <= cfg_data_i[14:0];
        msc_pkg::REG_AXIS_MAP: cfg_q.axis_map  <= cfg_data_i[5:0];
        msc_pkg::REG_AXIS_NEG: cfg_q.axis_neg  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Big-endian bytes to raw axis words
  assign raw[0] = {x_high_i, x_low_i};
  assign raw[1] = {y_high_i, y_low_i};
  assign raw[2] = {z_high_i, z_low_i};

  msc_core #(
    .UnityGain (UnityGain)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .raw_i       (raw),
    .res_valid_o (core_valid),
    .res_take_i  (res_take),
    .res_o       (core_res)
  );

  // Output register
  assign res_take = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && core_valid) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign body_x_o          = res_q.body[0];
  assign body_y_o          = res_q.body[1];
  assign body_z_o          = res_q.body[2];
  assign filtered_x_o      = res_q.filt[0];
  assign filtered_y_o      = res_q.filt[1];
  assign filtered_z_o      = res_q.filt[2];
  assign data_valid_o      = res_q.data_valid;
  assign restart_request_o = res_q.restart;

endmodule

`default_nettype wire
